// ===== rtl/eavt_pkg.sv =====
// ---------------------------------------------------------------------------
// eavt_pkg: shared definitions for the encoder value tracker
// Sequencer states, request codes, register indexes, arithmetic constants
// and the widths of the bit-serial divider and multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

package eavt_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_LOAD   = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MIN_IDX = 1'b0;
  localparam logic CFG_MAX_IDX = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;
  localparam int VAL_W     = 16;
  localparam int SPD_W     = 11;
  localparam int TIME_W    = 32;
  localparam int DELTA_W   = 17;

  // Reset values of the range registers.
  localparam logic signed [VAL_W-1:0] MIN_RESET = 16'sd0;
  localparam logic signed [VAL_W-1:0] MAX_RESET = 16'sd100;

  // Arithmetic constants.
  localparam int SPEED_LIMIT  = 999;
  localparam int SPAN_DIVISOR = 50;
  localparam int RATIO_DIVISOR = 10 * 1000 / 100;
  localparam int MULT_MIN     = 5;

  // Bit-serial datapath sizes.
  localparam int DIV_W      = 26;  // widest dividend: |delta| * 1000
  localparam int REM_W      = 32;  // remainder, as wide as the divisor
  localparam int SPAN_BITS  = 16;  // non-negative span
  localparam int RATIO_BITS = 21;  // |speed| * span / 50
  localparam int Q50_W      = 11;
  localparam int MAG_W      = 10;
  localparam int MULT_W     = 14;
  localparam int ACC_W      = 21;
  localparam int CNT_W      = 5;
  localparam int SUM_W      = 28;

  typedef enum logic [3:0] {
    ST_SPAN,
    ST_SPAN_DIV,
    ST_IDLE,
    ST_PREP,
    ST_SPD_DIV,
    ST_AVG,
    ST_MAG_MUL,
    ST_RATIO,
    ST_RAT_DIV,
    ST_STEP,
    ST_STEP_MUL,
    ST_CLAMP,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/encoder_accel_value_tracker_top.sv =====
// ---------------------------------------------------------------------------
// encoder_accel_value_tracker_top: accelerated, clamped encoder value
// Converts encoder count samples into a speed-scaled step on a tracked value
// using one bit-serial divider and one shift-add multiplier.
// ---------------------------------------------------------------------------
// A load beat, or a sample beat whose count equals the previous one, gives
// its result in the next cycle when the result register is free.
// If the previous result is still waiting on out_stall, the new result is
// kept in the tracker registers and in_stall stays high until it moves out.
// A sample with a changed count runs from PREP through the divide and
// multiply states to CLAMP and DONE; the next beat is taken back in IDLE.
// The shared restoring divider runs 26 steps for the speed and 21 for the
// ratio. The shift-add multiplier runs 10 steps for the scaled speed and 14
// for the value step, one bit per cycle each. The single-cycle states PREP,
// AVG, RATIO, STEP and CLAMP set up and finish the work. With a reversed
// range the scaling is skipped. After reset, and after every register
// write, the block recomputes span / 50 (no division for a reversed range)
// before it takes a beat. A finished result may wait on out_stall while the
// next beat is taken; a second result then waits inside the block.
`default_nettype none

module encoder_accel_value_tracker_top (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_req_type,
  input  wire signed [eavt_pkg::VAL_W-1:0]   in_hw_count,
  input  wire        [eavt_pkg::TIME_W-1:0]  in_now_ms,
  input  wire signed [eavt_pkg::VAL_W-1:0]   in_load_value,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [eavt_pkg::VAL_W-1:0]  out_value,
  output logic signed [eavt_pkg::SPD_W-1:0]  out_speed,
  input  wire                                cfg_we,
  input  wire        [eavt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire        [eavt_pkg::CFG_W-1:0]   cfg_wdata
);

  import eavt_pkg::*;

  state_t state_r, state_nxt;

  // Architectural state.
  logic signed [VAL_W-1:0]  min_r, max_r, value_r, last_count_r;
  logic        [TIME_W-1:0] last_time_r;
  logic signed [SPD_W-1:0]  avg_speed_r;
  logic                     span_neg_r;

  // Working registers.
  logic signed [DELTA_W-1:0] delta_r;
  logic [DIV_W-1:0]  div_q_r;
  logic [REM_W-1:0]  div_rem_r, div_dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [Q50_W-1:0]  q50_r;
  logic [ACC_W-1:0]  mul_acc_r, mul_mcand_r;
  logic [MULT_W-1:0] mul_mplr_r;
  logic              out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic signed [SPD_W-1:0] out_speed_r;

  // Handshake.
  logic in_acc, out_free, out_load, is_sample, changed, last_step;

  // Datapath.
  logic signed [DELTA_W-1:0] span;
  logic [REM_W:0]            div_sh;
  logic                      div_ge;
  logic [DIV_W-1:0]          div_q_nxt;
  logic [REM_W-1:0]          div_rem_nxt;
  logic [ACC_W-1:0]          mul_acc_nxt;
  logic [DELTA_W-1:0]        dmag;
  logic [DIV_W-1:0]          prod1000;
  logic [TIME_W-1:0]         elapsed;
  logic signed [SPD_W-1:0]   avg_plus, avg_halved;
  logic signed [SUM_W-1:0]   avg_ext, q_ext, spd_sum, spd_adj, spd_half;
  logic signed [SPD_W-1:0]   avg_new, avg_new_abs;
  logic [MULT_W-1:0]         step_mult;
  logic signed [VAL_W-1:0]   step_sum, clamp_hi, clamped;

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_speed = out_speed_r;

  assign is_sample = (in_req_type == REQ_SAMPLE);
  assign changed   = (in_hw_count != last_count_r);
  assign last_step = (cnt_r == CNT_W'(1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SPAN:     state_nxt = span[DELTA_W-1] ? ST_IDLE : ST_SPAN_DIV;
      ST_SPAN_DIV: if (last_step) state_nxt = ST_IDLE;
      ST_IDLE: begin
        // A short result that finds the result register busy waits in DONE.
        if (in_acc) begin
          if (is_sample && changed)
            state_nxt = ST_PREP;
          else if (!out_free)
            state_nxt = ST_DONE;
        end
      end
      ST_PREP:     state_nxt = ST_SPD_DIV;
      ST_SPD_DIV:  if (last_step) state_nxt = ST_AVG;
      ST_AVG:      state_nxt = span_neg_r ? ST_STEP : ST_MAG_MUL;
      ST_MAG_MUL:  if (last_step) state_nxt = ST_RATIO;
      ST_RATIO:    state_nxt = ST_RAT_DIV;
      ST_RAT_DIV:  if (last_step) state_nxt = ST_STEP;
      ST_STEP:     state_nxt = ST_STEP_MUL;
      ST_STEP_MUL: if (last_step) state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
    // A register write changes the span, so the quotient is rebuilt.
    if (cfg_we) state_nxt = ST_SPAN;
  end

  // Handshake outputs.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    in_stall = (state_r != ST_IDLE);
    in_acc   = in_valid && !in_stall;
    out_load = (in_acc && !(is_sample && changed) && out_free) ||
               ((state_r == ST_DONE) && out_free);
  end

  // Arithmetic.
  always_comb begin
    span = {max_r[VAL_W-1], max_r} - {min_r[VAL_W-1], min_r};

    div_sh      = {div_rem_r, div_q_r[DIV_W-1]};
    div_ge      = (div_sh >= {1'b0, div_dvs_r});
    div_rem_nxt = div_ge ? REM_W'(div_sh - {1'b0, div_dvs_r}) : div_sh[REM_W-1:0];
    div_q_nxt   = {div_q_r[DIV_W-2:0], div_ge};

    mul_acc_nxt = mul_mplr_r[0] ? (mul_acc_r + mul_mcand_r) : mul_acc_r;

    elapsed = in_now_ms - last_time_r;

    // |delta| * 1000 as 1024 - 16 - 8 times the magnitude.
    dmag     = delta_r[DELTA_W-1] ? DELTA_W'(-delta_r) : DELTA_W'(delta_r);
    prod1000 = {dmag[VAL_W-1:0], 10'b0}
             - {6'b0, dmag[VAL_W-1:0], 4'b0}
             - {7'b0, dmag[VAL_W-1:0], 3'b0};

    // Halving towards zero: add one to negative values before the shift.
    avg_plus   = avg_speed_r + $signed({{(SPD_W-1){1'b0}}, avg_speed_r[SPD_W-1]});
    avg_halved = avg_plus >>> 1;

    avg_ext  = SUM_W'(avg_speed_r);
    q_ext    = $signed({2'b0, div_q_r});
    spd_sum  = delta_r[DELTA_W-1] ? (avg_ext - q_ext) : (avg_ext + q_ext);
    spd_adj  = spd_sum + $signed({{(SUM_W-1){1'b0}}, spd_sum[SUM_W-1]});
    spd_half = spd_adj >>> 1;
    if ((spd_half > $signed(SUM_W'(SPEED_LIMIT))) ||
        (spd_half < -$signed(SUM_W'(SPEED_LIMIT))))
      avg_new = '0;
    else
      avg_new = spd_half[SPD_W-1:0];
    avg_new_abs = avg_new[SPD_W-1] ? -avg_new : avg_new;

    if (span_neg_r || (div_q_r < DIV_W'(MULT_MIN)))
      step_mult = MULT_W'(1);
    else
      step_mult = div_q_r[MULT_W-1:0];

    step_sum = $signed(mul_acc_r[VAL_W-1:0]);
    clamp_hi = (step_sum > max_r) ? max_r : step_sum;
    clamped  = (clamp_hi < min_r) ? min_r : clamp_hi;
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SPAN;
      out_valid_r  <= 1'b0;
      min_r        <= MIN_RESET;
      max_r        <= MAX_RESET;
      value_r      <= '0;
      last_count_r <= '0;
      last_time_r  <= '0;
      avg_speed_r  <= '0;
      span_neg_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;

      if (cfg_we) begin
        if (cfg_index == CFG_MIN_IDX) min_r <= $signed(cfg_wdata);
        if (cfg_index == CFG_MAX_IDX) max_r <= $signed(cfg_wdata);
      end

      if (cfg_we)
        value_r <= '0;
      else if (in_acc && !is_sample)
        value_r <= in_load_value;
      else if (state_r == ST_CLAMP)
        value_r <= clamped;

      if (in_acc && is_sample && changed) begin
        last_count_r <= in_hw_count;
        last_time_r  <= in_now_ms;
      end

      if (in_acc && is_sample && !changed)
        avg_speed_r <= avg_halved;
      else if (state_r == ST_AVG)
        avg_speed_r <= avg_new;

      if (state_r == ST_SPAN)
        span_neg_r <= span[DELTA_W-1];
    end
  end

  // Serial datapath and result register.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_SPAN: begin
        div_q_r   <= {span[SPAN_BITS-1:0], {(DIV_W-SPAN_BITS){1'b0}}};
        div_rem_r <= '0;
        div_dvs_r <= REM_W'(SPAN_DIVISOR);
        cnt_r     <= CNT_W'(SPAN_BITS);
      end
      ST_IDLE: begin
        if (in_acc && is_sample && changed) begin
          delta_r   <= {in_hw_count[VAL_W-1], in_hw_count}
                     - {last_count_r[VAL_W-1], last_count_r};
          div_dvs_r <= (elapsed == '0) ? TIME_W'(1) : elapsed;
        end
      end
      ST_PREP: begin
        div_q_r   <= prod1000;
        div_rem_r <= '0;
        cnt_r     <= CNT_W'(DIV_W);
      end
      ST_SPAN_DIV, ST_SPD_DIV, ST_RAT_DIV: begin
        div_q_r   <= div_q_nxt;
        div_rem_r <= div_rem_nxt;
        cnt_r     <= cnt_r - CNT_W'(1);
        if ((state_r == ST_SPAN_DIV) && last_step)
          q50_r <= div_q_nxt[Q50_W-1:0];
      end
      ST_AVG: begin
        mul_acc_r   <= '0;
        mul_mcand_r <= ACC_W'(q50_r);
        mul_mplr_r  <= MULT_W'(avg_new_abs[MAG_W-1:0]);
        cnt_r       <= CNT_W'(MAG_W);
      end
      ST_MAG_MUL, ST_STEP_MUL: begin
        mul_acc_r   <= mul_acc_nxt;
        mul_mcand_r <= {mul_mcand_r[ACC_W-2:0], 1'b0};
        mul_mplr_r  <= mul_mplr_r >> 1;
        cnt_r       <= cnt_r - CNT_W'(1);
      end
      ST_RATIO: begin
        // Left-align the dividend so that the quotient ends in the low bits.
        div_q_r   <= {mul_acc_r, {(DIV_W-RATIO_BITS){1'b0}}};
        div_rem_r <= '0;
        div_dvs_r <= REM_W'(RATIO_DIVISOR);
        cnt_r     <= CNT_W'(RATIO_BITS);
      end
      ST_STEP: begin
        // Only the low 16 bits of the sum survive the wrap.
        mul_acc_r   <= ACC_W'($unsigned(value_r));
        mul_mcand_r <= ACC_W'(delta_r[VAL_W-1:0]);
        mul_mplr_r  <= step_mult;
        cnt_r       <= CNT_W'(MULT_W);
      end
      default: begin
      end
    endcase

    if (out_load) begin
      if (state_r == ST_DONE) begin
        out_value_r <= value_r;
        out_speed_r <= avg_speed_r;
      end else if (!is_sample) begin
        out_value_r <= in_load_value;
        out_speed_r <= avg_speed_r;
      end else begin
        out_value_r <= value_r;
        out_speed_r <= avg_halved;
      end
    end
  end

endmodule

`default_nettype wire
